// ===== hw/rtl/crc8_checked_command_frame_decoder_core_assert.svh =====
// assertion helpers for the poll-frame decoder
// the enclosing module must provide clk and rst_n
`ifndef CRC8_CHECKED_COMMAND_FRAME_DECODER_CORE_ASSERT_SVH
`define CRC8_CHECKED_COMMAND_FRAME_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define CCFD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ccfd assertion failed");

// next-cycle implication
`define CCFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ccfd assertion failed");

`endif

// ===== hw/rtl/ccfd_pkg.sv =====
`default_nettype none

package ccfd_pkg;

  // crc-8 parameters, msb first, no reflection, no final xor
  localparam logic [7:0] CrcInit = 8'hFF;
  localparam logic [7:0] CrcPoly = 8'h31;

  // command codes
  localparam logic [7:0] CMD_MODE_ONE  = 8'd42;
  localparam logic [7:0] CMD_MODE_ZERO = 8'd43;
  localparam logic [7:0] CMD_SINGLE    = 8'd45;

  typedef enum logic [1:0] {
    KIND_MODE_ONE  = 2'd0,
    KIND_MODE_ZERO = 2'd1,
    KIND_SINGLE    = 2'd2,
    KIND_OTHER     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_ZERO  = 2'd0,
    MODE_ONE   = 2'd1,
    MODE_UNSET = 2'd2
  } mode_t;

  // input word: one poll frame
  typedef struct packed {
    logic [7:0] command_byte;
    logic [7:0] slow_channel;
    logic [7:0] contact_channel;
    logic [7:0] check_byte;
  } in_word_t;

  // result word
  typedef struct packed {
    logic       crc_ok;
    logic [7:0] computed_crc;
    logic [1:0] command_kind;
    logic [1:0] mode_now;
    logic       run_request;
    logic       transmit_enable;
    logic       single_sample_request;
    logic [7:0] slow_channel_out;
    logic [7:0] contact_channel_out;
  } out_word_t;

  // sticky control state
  typedef struct packed {
    mode_t mode;
    logic  run;
    logic  xmit;
    logic  single;
  } state_t;

  // frame check info handed to the control block
  typedef struct packed {
    logic       upd;
    logic       crc_ok;
    logic [7:0] cmd;
  } chk_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ccfd_in_if.sv =====
`default_nettype none

interface ccfd_in_if;
  logic               valid;
  logic               ready;
  ccfd_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ccfd_out_if.sv =====
`default_nettype none

interface ccfd_out_if;
  logic                valid;
  logic                ready;
  ccfd_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ccfd_crc.sv =====
`default_nettype none

module ccfd_crc (
  input  logic [7:0] cmd,
  input  logic [7:0] slow,
  input  logic [7:0] contact,
  output logic [7:0] crc
);

  // one crc-8 byte step, eight shift/xor stages
  function automatic logic [7:0] crc_step(input logic [7:0] crc_in, input logic [7:0] din);
    logic [7:0] c;
    c = crc_in ^ din;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ ccfd_pkg::CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  logic [7:0] crc_a;
  logic [7:0] crc_b;

  // three chained byte steps
  always_comb begin
    crc_a = crc_step(ccfd_pkg::CrcInit, cmd);
    crc_b = crc_step(crc_a, slow);
    crc   = crc_step(crc_b, contact);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ccfd_ctl.sv =====
`default_nettype none

`include "crc8_checked_command_frame_decoder_core_assert.svh"

module ccfd_ctl (
  input  logic              clk,
  input  logic              rst_n,
  input  ccfd_pkg::chk_t    chk,
  output ccfd_pkg::kind_t   kind,
  output ccfd_pkg::state_t  state_nxt
);

  ccfd_pkg::state_t st_r;

  // command decode and state update for this frame
  always_comb begin
    state_nxt = st_r;
    case (chk.cmd)
      ccfd_pkg::CMD_MODE_ONE: begin
        kind = ccfd_pkg::KIND_MODE_ONE;
        if (chk.crc_ok) begin
          state_nxt.mode = ccfd_pkg::MODE_ONE;
          state_nxt.run  = 1'b1;
          state_nxt.xmit = 1'b1;
        end
      end
      ccfd_pkg::CMD_MODE_ZERO: begin
        kind = ccfd_pkg::KIND_MODE_ZERO;
        if (chk.crc_ok) begin
          state_nxt.mode = ccfd_pkg::MODE_ZERO;
          state_nxt.run  = 1'b1;
          state_nxt.xmit = 1'b1;
        end
      end
      ccfd_pkg::CMD_SINGLE: begin
        kind = ccfd_pkg::KIND_SINGLE;
        // mode zero is forced even on a bad crc
        state_nxt.mode = ccfd_pkg::MODE_ZERO;
        if (chk.crc_ok) begin
          state_nxt.single = 1'b1;
        end
      end
      default: begin
        kind = ccfd_pkg::KIND_OTHER;
        if (chk.crc_ok) begin
          state_nxt.run  = 1'b1;
          state_nxt.xmit = 1'b0;
        end
      end
    endcase
  end

  // state register, advances once per frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode   <= ccfd_pkg::MODE_UNSET;
      st_r.run    <= 1'b0;
      st_r.xmit   <= 1'b1;
      st_r.single <= 1'b0;
    end else if (chk.upd) begin
      st_r <= state_nxt;
    end
  end

  // request flags stay set until reset, mode never goes back to unset
  `CCFD_ASSERT_NEXT(a_run_sticky, st_r.run, st_r.run)
  `CCFD_ASSERT_NEXT(a_single_sticky, st_r.single, st_r.single)
  `CCFD_ASSERT_NEXT(a_mode_stays_set, st_r.mode != ccfd_pkg::MODE_UNSET,
                    st_r.mode != ccfd_pkg::MODE_UNSET)

endmodule

`default_nettype wire

// ===== hw/rtl/crc8_checked_command_frame_decoder_core.sv =====
// Poll-frame decoder: each input word is one four-byte frame (command, slow
// channel, contact channel, check byte). The CRC-8 (poly 0x31, init 0xFF, msb
// first) of the first three bytes is compared with the check byte, and the
// command updates sticky mode and request flags that are reported with every
// result along with the two channel numbers. One frame per clock is sustained
// while the result side is ready; a result passes through the input register and
// then the result register, and the three chained CRC byte steps plus decode
// between those registers set the cycle time. Stalls on the result side back up
// through ready without losing or repeating words.
`default_nettype none

`include "crc8_checked_command_frame_decoder_core_assert.svh"

module crc8_checked_command_frame_decoder_core (
  input  logic            clk,
  input  logic            rst_n,
  ccfd_in_if.sink         in_ch,
  ccfd_out_if.source      out_ch
);

  logic                s1_valid_r;
  ccfd_pkg::in_word_t  s1_data_r;
  logic                s1_adv;
  logic                out_valid_r;
  logic                out_valid_nxt;
  ccfd_pkg::out_word_t out_data_r;
  ccfd_pkg::out_word_t out_data_nxt;
  logic [7:0]          crc;
  logic                crc_ok;
  ccfd_pkg::chk_t      chk;
  ccfd_pkg::kind_t     kind;
  ccfd_pkg::state_t    state_nxt;

  // handshake: stage one moves when the result register is free or draining
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_ch.ready);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_data_r <= in_ch.data;
    end
  end

  // crc over the three leading bytes
  ccfd_crc u_crc (
    .cmd     (s1_data_r.command_byte),
    .slow    (s1_data_r.slow_channel),
    .contact (s1_data_r.contact_channel),
    .crc     (crc)
  );

  assign crc_ok     = (crc == s1_data_r.check_byte);
  assign chk.upd    = s1_adv;
  assign chk.crc_ok = crc_ok;
  assign chk.cmd    = s1_data_r.command_byte;

  // command decode and sticky state
  ccfd_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .chk       (chk),
    .kind      (kind),
    .state_nxt (state_nxt)
  );

  // result word assembly
  always_comb begin
    out_data_nxt.crc_ok                = crc_ok;
    out_data_nxt.computed_crc          = crc;
    out_data_nxt.command_kind          = kind;
    out_data_nxt.mode_now              = state_nxt.mode;
    out_data_nxt.run_request           = state_nxt.run;
    out_data_nxt.transmit_enable       = state_nxt.xmit;
    out_data_nxt.single_sample_request = state_nxt.single;
    out_data_nxt.slow_channel_out      = s1_data_r.slow_channel;
    out_data_nxt.contact_channel_out   = s1_data_r.contact_channel;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // a frame leaving stage one is always shown next cycle
  `CCFD_ASSERT_NEXT(a_adv_shows_result, s1_adv, out_valid_r)
  // a single-sample frame always leaves mode zero behind
  `CCFD_ASSERT_NEXT(a_single_forces_mode_zero,
                    s1_adv && (s1_data_r.command_byte == ccfd_pkg::CMD_SINGLE),
                    out_data_r.mode_now == ccfd_pkg::MODE_ZERO)
  // a good frame with an ordinary command turns transmit off
  `CCFD_ASSERT_NEXT(a_other_ok_no_xmit,
                    s1_adv && crc_ok && (kind == ccfd_pkg::KIND_OTHER),
                    !out_data_r.transmit_enable && out_data_r.run_request)

endmodule

`default_nettype wire
